FILE: rtl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// Euler to quaternion package
// Shared types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package e2q_pkg;

	localparam int MAX_STAGES = 24;

	// Arctangent of 2^-i, 2^32 units per full turn.
	function automatic logic signed [33:0] atan_entry(input int idx);
		logic signed [33:0] t;
		begin
			unique case (idx)
				0: t = 34'sd536870912;
				1: t = 34'sd316933406;
				2: t = 34'sd167458907;
				3: t = 34'sd85004756;
				4: t = 34'sd42667331;
				5: t = 34'sd21354465;
				6: t = 34'sd10680862;
				7: t = 34'sd5340757;
				8: t = 34'sd2670675;
				9: t = 34'sd1335087;
				10: t = 34'sd667544;
				11: t = 34'sd333772;
				12: t = 34'sd166886;
				13: t = 34'sd83443;
				14: t = 34'sd41722;
				15: t = 34'sd20861;
				16: t = 34'sd10430;
				17: t = 34'sd5215;
				18: t = 34'sd2608;
				19: t = 34'sd1304;
				20: t = 34'sd652;
				21: t = 34'sd326;
				22: t = 34'sd163;
				23: t = 34'sd81;
				default: t = 34'sd0;
			endcase
			return t;
		end
	endfunction

	// Sideband carried alongside the data through the back end.
	typedef struct packed {
		logic all_present;
	} e2q_side_t;

endpackage

FILE: rtl/e2q_front.sv
// ----------------------------------------------------------------------------
// Euler to quaternion front end
// Accepts words, applies valid bits and forms the half angles.
// ----------------------------------------------------------------------------
module e2q_front #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ANGLE_BITS-1:0]        yaw,
	input  logic [ANGLE_BITS-1:0]        pitch,
	input  logic [ANGLE_BITS-1:0]        roll,
	input  logic [2:0]                   vld,
	output logic                         f_valid,
	input  logic                         f_ready,
	output logic signed [33:0]           z_yaw,
	output logic signed [33:0]           z_pitch,
	output logic signed [33:0]           z_roll,
	output e2q_pkg::e2q_side_t           f_side
);
	import e2q_pkg::*;

	logic signed [33:0] za_q, zb_q, zc_q;
	e2q_side_t side_q;
	logic valid_q;

	// Half angle in 2^32 per turn: sign-extend and shift up.
	function automatic logic signed [33:0] half(input logic [ANGLE_BITS-1:0] a,
		input logic v);
		logic signed [33:0] e;
		begin
			e = 34'(signed'(a));
			return v ? (e <<< (31 - ANGLE_BITS)) : 34'sd0;
		end
	endfunction

	assign in_ready = !valid_q || f_ready;

	// Registered hand-off stage toward the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			za_q <= half(yaw, vld[0]);
			zb_q <= half(pitch, vld[1]);
			zc_q <= half(roll, vld[2]);
			side_q.all_present <= &vld;
		end
	end

	assign f_valid = valid_q;
	assign z_yaw = za_q;
	assign z_pitch = zb_q;
	assign z_roll = zc_q;
	assign f_side = side_q;
endmodule

FILE: rtl/e2q_fifo.sv
// ----------------------------------------------------------------------------
// Euler to quaternion queue
// Short queue between front and back ends.
// ----------------------------------------------------------------------------
module e2q_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr_en, rd_en;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr_en = wr_valid && wr_ready;
	assign rd_en = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end
endmodule

FILE: rtl/e2q_back.sv
// ----------------------------------------------------------------------------
// Euler to quaternion back end
// Pipelined CORDIC for three angles, then two quaternion products.
// ----------------------------------------------------------------------------
module e2q_back #(
	parameter int FRACTION_BITS = 14,
	parameter int CORDIC_STAGES = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       b_valid,
	output logic                       b_ready,
	input  logic signed [33:0]         z_yaw,
	input  logic signed [33:0]         z_pitch,
	input  logic signed [33:0]         z_roll,
	input  e2q_pkg::e2q_side_t         b_side,
	output logic                       o_valid,
	input  logic                       o_ready,
	output logic [FRACTION_BITS+1:0]   qw,
	output logic [FRACTION_BITS+1:0]   qx,
	output logic [FRACTION_BITS+1:0]   qy,
	output logic [FRACTION_BITS+1:0]   qz,
	output e2q_pkg::e2q_side_t         o_side
);
	import e2q_pkg::*;

	localparam int NS = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
	localparam int WB = FRACTION_BITS + 5;        // CORDIC working width
	localparam int SH = 32 - (FRACTION_BITS + 2);
	localparam longint KQ = 64'd2608131497;
	localparam longint KN = KQ + ((KQ * 2 / 3) >> (2 * NS));
	localparam longint X0 = (SH == 0) ? KN : ((KN + (64'd1 << (SH - 1))) >> SH);
	localparam int CW = FRACTION_BITS + 2;        // sin/cos width
	localparam int PW = 2 * CW + 2;               // product sum width
	localparam int NST = NS + 6;                  // total pipeline stages
	localparam int OB = FRACTION_BITS + 2;

	// Whole pipeline advances together; an output register decouples the port.
	logic adv;
	logic [NST-1:0] vld_q;
	e2q_side_t side_q [NST];

	logic signed [WB-1:0] cx_q [3][NS+1];
	logic signed [WB-1:0] cy_q [3][NS+1];
	logic signed [33:0]   cz_q [3][NS+1];

	logic out_full_q;
	assign adv = !out_full_q || o_ready;
	assign b_ready = adv;

	// Valid and sideband shift line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], b_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= b_side;
			for (int k = 1; k < NST; k++) side_q[k] <= side_q[k-1];
		end
	end

	// CORDIC entry stage.
	always_ff @(posedge clk) begin
		if (adv) begin
			cx_q[0][0] <= WB'(X0);
			cx_q[1][0] <= WB'(X0);
			cx_q[2][0] <= WB'(X0);
			cy_q[0][0] <= '0;
			cy_q[1][0] <= '0;
			cy_q[2][0] <= '0;
			cz_q[0][0] <= z_yaw;
			cz_q[1][0] <= z_pitch;
			cz_q[2][0] <= z_roll;
		end
	end

	// CORDIC rotation stages, one micro-rotation per stage.
	for (genvar i = 0; i < NS; i++) begin : g_cordic
		for (genvar a = 0; a < 3; a++) begin : g_axis
			always_ff @(posedge clk) begin
				if (adv) begin
					if (!cz_q[a][i][33]) begin
						cx_q[a][i+1] <= cx_q[a][i] - (cy_q[a][i] >>> i);
						cy_q[a][i+1] <= cy_q[a][i] + (cx_q[a][i] >>> i);
						cz_q[a][i+1] <= cz_q[a][i] - atan_entry(i);
					end else begin
						cx_q[a][i+1] <= cx_q[a][i] + (cy_q[a][i] >>> i);
						cy_q[a][i+1] <= cy_q[a][i] - (cx_q[a][i] >>> i);
						cz_q[a][i+1] <= cz_q[a][i] + atan_entry(i);
					end
				end
			end
		end
	end

	// Round the CORDIC outputs to sine and cosine.
	function automatic logic signed [CW-1:0] rnd2(input logic signed [WB-1:0] v);
		logic signed [WB-1:0] t;
		begin
			t = (v + WB'(2)) >>> 2;
			return t[CW-1:0];
		end
	endfunction

	function automatic logic signed [PW-1:0] rndf(input logic signed [PW-1:0] v);
		begin
			return (v + (PW'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
		end
	endfunction

	logic signed [CW-1:0] cy_s1, sy_s1, cp_s1, sp_s1, cr_s1, sr_s1;
	// First product terms: yaw times pitch (yaw has only w and -y).
	logic signed [PW-1:0] m0_s2, m1_s2, m2_s2, m3_s2;
	logic signed [CW-1:0] tw_s3, tx_s3, ty_s3, tz_s3, cr_s3, sr_s3;
	logic signed [CW-1:0] cr_s2, sr_s2;
	logic signed [PW-1:0] p_s4 [8];
	logic signed [PW-1:0] w_s5, x_s5, y_s5, z_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			cy_s1 <= rnd2(cx_q[0][NS]); sy_s1 <= rnd2(cy_q[0][NS]);
			cp_s1 <= rnd2(cx_q[1][NS]); sp_s1 <= rnd2(cy_q[1][NS]);
			cr_s1 <= rnd2(cx_q[2][NS]); sr_s1 <= rnd2(cy_q[2][NS]);
			// t = (cy,0,-sy,0)*(cp,sp,0,0)
			m0_s2 <= PW'(cy_s1 * cp_s1);
			m1_s2 <= PW'(cy_s1 * sp_s1);
			m2_s2 <= PW'(-(sy_s1 * cp_s1));
			m3_s2 <= PW'(sy_s1 * sp_s1);
			cr_s2 <= cr_s1; sr_s2 <= sr_s1;
			tw_s3 <= CW'(rndf(m0_s2));
			tx_s3 <= CW'(rndf(m1_s2));
			ty_s3 <= CW'(rndf(m2_s2));
			tz_s3 <= CW'(rndf(m3_s2));
			cr_s3 <= cr_s2; sr_s3 <= sr_s2;
			// q = t*(cr,0,0,-sr)
			p_s4[0] <= PW'(tw_s3 * cr_s3);
			p_s4[1] <= PW'(tz_s3 * sr_s3);
			p_s4[2] <= PW'(tx_s3 * cr_s3);
			p_s4[3] <= PW'(ty_s3 * sr_s3);
			p_s4[4] <= PW'(ty_s3 * cr_s3);
			p_s4[5] <= PW'(tx_s3 * sr_s3);
			p_s4[6] <= PW'(tw_s3 * sr_s3);
			p_s4[7] <= PW'(tz_s3 * cr_s3);
			w_s5 <= rndf(p_s4[0] + p_s4[1]);
			x_s5 <= rndf(p_s4[2] - p_s4[3]);
			y_s5 <= rndf(p_s4[4] + p_s4[5]);
			z_s5 <= rndf(p_s4[7] - p_s4[6]);
		end
	end

	function automatic logic [OB-1:0] sat(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] one;
		begin
			one = PW'(1) <<< FRACTION_BITS;
			if (v > one) return OB'(one);
			else if (v < -one) return OB'(-one);
			else return v[OB-1:0];
		end
	endfunction

	// Output register.
	logic [OB-1:0] ow_q, ox_q, oy_q, oz_q;
	e2q_side_t os_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (adv) begin
			out_full_q <= vld_q[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ow_q <= sat(w_s5); ox_q <= sat(x_s5);
			oy_q <= sat(y_s5); oz_q <= sat(z_s5);
			os_q <= side_q[NST-1];
		end
	end

	assign o_valid = out_full_q;
	assign qw = ow_q;
	assign qx = ox_q;
	assign qy = oy_q;
	assign qz = oz_q;
	assign o_side = os_q;
endmodule

FILE: rtl/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// Euler to quaternion
// Converts yaw, pitch and roll binary angles to a Q1.14 attitude quaternion.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// s_axis   in   tdata: yaw, pitch, roll angles; tuser: yaw, pitch, roll valid
// m_axis   out  tdata: w, x, y, z; tuser: all angles present
//
// One word is accepted per cycle while the queue has room; a result passes
// the three parallel CORDIC pipelines and then two quaternion products.
// Reset clears all valid flags; no clearing pass is needed.
// A stall on m_axis halts the back end; the queue absorbs front-end words.
module euler_to_quaternion #(
	parameter int ANGLE_BITS = 16,
	parameter int FRACTION_BITS = 14,
	parameter int CORDIC_STAGES = 14
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// yaw_angle, pitch_angle, roll_angle, zero fill
	input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	// yaw_valid, pitch_valid, roll_valid
	input  logic [2:0]                     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// quat_w, quat_x, quat_y, quat_z, zero fill
	output logic [((4*(FRACTION_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
	// all_angles_present
	output logic                           m_axis_tuser
);
	import e2q_pkg::*;

	localparam int OB = FRACTION_BITS + 2;
	localparam int QW = 3 * 34 + 1;
	localparam int TDW = ((4 * OB + 7) / 8) * 8;

	logic f_valid, f_ready, b_valid, b_ready, o_valid;
	logic signed [33:0] za, zb, zc;
	e2q_side_t f_side, o_side;
	logic [QW-1:0] qin, qout;
	logic [OB-1:0] qw, qx, qy, qz;

	e2q_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.yaw(s_axis_tdata[ANGLE_BITS-1:0]),
		.pitch(s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
		.roll(s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]),
		.vld(s_axis_tuser),
		.f_valid, .f_ready,
		.z_yaw(za), .z_pitch(zb), .z_roll(zc), .f_side
	);

	assign qin = {f_side, zc, zb, za};

	e2q_fifo #(.WIDTH(QW)) u_fifo (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(qin),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(qout)
	);

	e2q_back #(.FRACTION_BITS(FRACTION_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
		.clk, .arst_n,
		.b_valid, .b_ready,
		.z_yaw(qout[33:0]), .z_pitch(qout[67:34]), .z_roll(qout[101:68]),
		.b_side(qout[QW-1]),
		.o_valid, .o_ready(m_axis_tready),
		.qw, .qx, .qy, .qz, .o_side
	);

	assign m_axis_tvalid = o_valid;
	assign m_axis_tdata = TDW'({qz, qy, qx, qw});
	assign m_axis_tuser = o_side.all_present;

	// Assertions.
	a_side_present: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> u_front.f_valid)
		else $error("accepted word did not reach front register");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped under stall");
	a_range_w: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[OB-1:0]) <= $signed(OB'(1) <<< FRACTION_BITS)))
		else $error("w out of range");
endmodule
